// ===== src/contiguous_block_allocator_compacting_core_macros.svh =====
// assertion macros for the compacting block allocator
// expects clk_i and rst_ni in the scope of use
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_COMPACTING_CORE_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_COMPACTING_CORE_MACROS_SVH

// same-cycle implication
`define CBAC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbac assertion failed");

// next-cycle implication
`define CBAC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbac assertion failed");

`endif

// ===== src/cbac_pkg.sv =====
// shared types and constants of the compacting block allocator
// no dependencies
package cbac_pkg;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdBits    = 16;

  localparam int unsigned BlkW  = 7;
  localparam int unsigned IdW   = 16;

  localparam logic [BlkW-1:0] NumBlocksRst = 7'd64;

  typedef logic [IdW-1:0] owner_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_BLOCK  = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

endpackage

// ===== src/cbac_mem.sv =====
// block owner table: one write port, one registered read port
// entries read as zero until first written; uses no package
module cbac_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rdat_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdat_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdat_q : '0;

endmodule

// ===== src/cbac_ctrl.sv =====
// sequencer: range check, pack, tail clear and listing over the owner table
// depends on cbac_pkg; drives the ports of cbac_mem
module cbac_ctrl #(
  parameter int unsigned MaxBlocks = cbac_pkg::MaxBlocks,
  parameter int unsigned IdBits    = cbac_pkg::IdBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   opcode_i,
  input  logic [cbac_pkg::BlkW-1:0]    start_block_i,
  input  logic [cbac_pkg::BlkW-1:0]    length_i,
  input  logic [cbac_pkg::IdW-1:0]     target_id_i,
  input  logic [cbac_pkg::BlkW-1:0]    num_blocks_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  output logic [1:0]                   kind_o,
  output logic                         status_o,
  output logic [cbac_pkg::IdW-1:0]     owner_id_o,
  output logic                         last_o,
  output logic                         mem_we_o,
  output logic [$clog2(MaxBlocks)-1:0] mem_waddr_o,
  output logic [IdBits-1:0]            mem_wdata_o,
  output logic [$clog2(MaxBlocks)-1:0] mem_raddr_o,
  input  logic [IdBits-1:0]            mem_rdata_i
);

  localparam int unsigned AW = $clog2(MaxBlocks);
  localparam int unsigned CW = $clog2(MaxBlocks + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_PACK   = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_LIST   = 3'd4;
  localparam logic [2:0] S_STATUS = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [IdBits-1:0] id_q, id_d, tgt_q, tgt_d, next_id_q, next_id_d;
  logic              ok_q, ok_d;
  logic [CW-1:0]     ra_q, ra_d, end_q, end_d, rpa_q, rpa_d, w_q, w_d;
  logic [CW-1:0]     used_q, used_d;
  logic              rv_q, rv_d;
  logic              res_valid_q, res_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic              status_q, status_d, last_q, last_d;
  logic [cbac_pkg::IdW-1:0] owner_q, owner_d;

  logic [CW-1:0]     n_w, cnt_w;
  logic [7:0]        span_w;
  logic              fit_w, issue_w, done_w, in_rng_w, del_hit_w;
  logic [IdBits-1:0] val_w, nid_w;

  always_comb begin
    if (num_blocks_i == '0) begin
      n_w = CW'(1);
    end else if (num_blocks_i > cbac_pkg::BlkW'(MaxBlocks)) begin
      n_w = CW'(MaxBlocks);
    end else begin
      n_w = CW'(num_blocks_i);
    end
  end

  assign cnt_w   = (used_q < n_w) ? used_q : n_w;
  assign span_w  = {1'b0, start_block_i} + {1'b0, length_i} - 8'd1;
  assign fit_w   = (start_block_i != '0) && (span_w <= 8'(n_w));
  assign issue_w = (ra_q != end_q);
  assign done_w  = !issue_w && !rv_q;
  assign nid_w   = (next_id_q + IdBits'(1) == '0) ? IdBits'(1) : next_id_q + IdBits'(1);

  assign in_rng_w  = ok_q && (op_q == cbac_pkg::OP_INSERT) && (rpa_q >= lo_q) && (rpa_q < hi_q);
  assign del_hit_w = (op_q == cbac_pkg::OP_DELETE) && (tgt_q != '0) && (mem_rdata_i == tgt_q);
  assign val_w     = in_rng_w ? id_q : (del_hit_w ? '0 : mem_rdata_i);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    id_d        = id_q;
    tgt_d       = tgt_q;
    next_id_d   = next_id_q;
    ok_d        = ok_q;
    ra_d        = ra_q;
    end_d       = end_q;
    rpa_d       = rpa_q;
    w_d         = w_q;
    used_d      = used_q;
    rv_d        = 1'b0;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    status_d    = status_q;
    owner_d     = owner_q;
    last_d      = last_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = w_q[AW-1:0];
    mem_wdata_o = val_w;
    mem_raddr_o = ra_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = opcode_i;
          ra_d = '0;
          w_d  = '0;
          unique case (opcode_i)
            cbac_pkg::OP_INSERT: begin
              id_d      = next_id_q;
              next_id_d = nid_w;
              ok_d      = fit_w;
              lo_d      = CW'(start_block_i - 7'd1);
              hi_d      = CW'(span_w);
              ra_d      = CW'(start_block_i - 7'd1);
              end_d     = CW'(span_w);
              state_d   = fit_w ? S_CHECK : S_STATUS;
            end
            cbac_pkg::OP_DELETE: begin
              tgt_d   = IdBits'(target_id_i);
              end_d   = n_w;
              state_d = S_PACK;
            end
            cbac_pkg::OP_LIST: begin
              end_d   = cnt_w;
              state_d = S_LIST;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (issue_w) begin
          ra_d  = ra_q + CW'(1);
          rv_d  = 1'b1;
          rpa_d = ra_q;
        end
        if (rv_q && mem_rdata_i != '0) begin
          ok_d = 1'b0;
        end
        if (done_w) begin
          ra_d    = '0;
          w_d     = '0;
          end_d   = n_w;
          state_d = ok_q ? S_PACK : S_STATUS;
        end
      end
      S_PACK: begin
        if (issue_w) begin
          ra_d  = ra_q + CW'(1);
          rv_d  = 1'b1;
          rpa_d = ra_q;
        end
        if (rv_q && val_w != '0) begin
          mem_we_o = 1'b1;
          w_d      = w_q + CW'(1);
        end
        if (done_w) begin
          used_d  = w_q;
          ra_d    = w_q;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        mem_waddr_o = ra_q[AW-1:0];
        mem_wdata_o = '0;
        if (issue_w) begin
          mem_we_o = 1'b1;
          ra_d     = ra_q + CW'(1);
        end else if (op_q == cbac_pkg::OP_INSERT) begin
          state_d = S_STATUS;
        end else begin
          ra_d    = '0;
          end_d   = cnt_w;
          state_d = S_LIST;
        end
      end
      S_LIST: begin
        if (end_q == '0) begin
          res_valid_d = 1'b1;
          kind_d      = cbac_pkg::KIND_EMPTY;
          status_d    = 1'b0;
          owner_d     = '0;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end else begin
          if (issue_w) begin
            ra_d  = ra_q + CW'(1);
            rv_d  = 1'b1;
            rpa_d = ra_q;
          end else begin
            state_d = S_IDLE;
          end
          if (rv_q) begin
            res_valid_d = 1'b1;
            kind_d      = cbac_pkg::KIND_BLOCK;
            status_d    = 1'b0;
            owner_d     = cbac_pkg::owner_t'(mem_rdata_i);
            last_d      = (rpa_q == end_q - CW'(1));
          end
        end
      end
      S_STATUS: begin
        res_valid_d = 1'b1;
        kind_d      = cbac_pkg::KIND_STATUS;
        status_d    = !ok_q;
        owner_d     = cbac_pkg::owner_t'(id_q);
        last_d      = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_id_q   <= IdBits'(1);
      used_q      <= '0;
      rv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_id_q   <= next_id_d;
      used_q      <= used_d;
      rv_q        <= rv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    id_q     <= id_d;
    tgt_q    <= tgt_d;
    ok_q     <= ok_d;
    ra_q     <= ra_d;
    end_q    <= end_d;
    rpa_q    <= rpa_d;
    w_q      <= w_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    owner_q  <= owner_d;
    last_q   <= last_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign kind_o      = kind_q;
  assign status_o    = status_q;
  assign owner_id_o  = owner_q;
  assign last_o      = last_q;

endmodule

// ===== src/contiguous_block_allocator_compacting_core.sv =====
// top level of the compacting block allocator: config register, sequencer, table
// depends on cbac_pkg, cbac_ctrl, cbac_mem and the assertion macro header
//
// Usage: drive opcode_i and its fields with start_i; the item is taken at an edge
// where start_i is high and busy_o is low, one item at a time. busy_o is low again
// in the cycle that shows the last result, so the next item can be taken there.
// Results appear on kind_o, status_o, owner_id_o and last_o for exactly one cycle,
// marked by res_valid_o; the receiver cannot stall them. An insert gives one status
// result, a list or delete gives one result per occupied block (or a single empty
// marker), last_o flags the final one.
// Table size is written on cfg_valid_i/cfg_ready_o/cfg_data_i while idle, never in
// a cycle that starts an item.
// Each item steps through the states in order: an insert reads its range for a used
// block, then packs the table up to the size in use, clears the tail and gives its
// status (a bounds clash or a used block gives the status without packing); a delete
// packs, clears the tail and lists; a list reads the blocks in use. Every step is one
// access on the single read port and single write port of the table memory.
// Reset empties the table, sets the id counter to one and the size to 64.
`include "contiguous_block_allocator_compacting_core_macros.svh"

module contiguous_block_allocator_compacting_core #(
  parameter int unsigned MaxBlocks = cbac_pkg::MaxBlocks,
  parameter int unsigned IdBits    = cbac_pkg::IdBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [cbac_pkg::BlkW-1:0] start_block_i,
  input  logic [cbac_pkg::BlkW-1:0] length_i,
  input  logic [cbac_pkg::IdW-1:0]  target_id_i,
  output logic                      res_valid_o,
  output logic [1:0]                kind_o,
  output logic                      status_o,
  output logic [cbac_pkg::IdW-1:0]  owner_id_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cbac_pkg::BlkW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxBlocks);

  logic [cbac_pkg::BlkW-1:0] num_blocks_q;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [IdBits-1:0]         mem_wdata, mem_rdata;

  assign cfg_ready_o = !busy_o && !start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_blocks_q <= cbac_pkg::NumBlocksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_blocks_q <= cfg_data_i;
    end
  end

  cbac_ctrl #(
    .MaxBlocks(MaxBlocks),
    .IdBits   (IdBits)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .opcode_i     (opcode_i),
    .start_block_i(start_block_i),
    .length_i     (length_i),
    .target_id_i  (target_id_i),
    .num_blocks_i (num_blocks_q),
    .busy_o       (busy_o),
    .res_valid_o  (res_valid_o),
    .kind_o       (kind_o),
    .status_o     (status_o),
    .owner_id_o   (owner_id_o),
    .last_o       (last_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  cbac_mem #(
    .Depth(MaxBlocks),
    .Width(IdBits)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  `CBAC_ASSERT_NXT(a_cmd_busy, start_i && !busy_o && opcode_i != cbac_pkg::OP_NOP, busy_o)
  `CBAC_ASSERT_IMP(a_status_last, res_valid_o && kind_o == cbac_pkg::KIND_STATUS, last_o)
  `CBAC_ASSERT_IMP(a_empty_clean, res_valid_o && kind_o == cbac_pkg::KIND_EMPTY, last_o && owner_id_o == '0 && !status_o)
  `CBAC_ASSERT_IMP(a_write_busy, mem_we, busy_o)

endmodule
